FILE: src/sfp_pkg.sv
package sfp_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEAD_BYTE        = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_MESSAGE_ID = 1'b1;

  // reset values of the configuration registers
  localparam logic [7:0] HEAD_BYTE_RESET        = 8'd239;
  localparam logic [7:0] RANGE_MESSAGE_ID_RESET = 8'd81;

  // payload positions and value checked for the range sensor report
  localparam int         RANGE_INDEX_A     = 10;
  localparam int         RANGE_INDEX_B     = 17;
  localparam logic [7:0] RANGE_FLAG_VALUE  = 8'd1;

  // width of the length byte carried in a frame descriptor
  localparam int LEN_W = 8;

  // descriptor queue between the parser and the emitter
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // parser phases
  typedef enum logic [7:0] {
    PH_HUNT = 8'b0000_0001,
    PH_DEV  = 8'b0000_0010,
    PH_SYS  = 8'b0000_0100,
    PH_MSG  = 8'b0000_1000,
    PH_SEQ  = 8'b0001_0000,
    PH_LEN  = 8'b0010_0000,
    PH_DATA = 8'b0100_0000,
    PH_SUM  = 8'b1000_0000
  } phase_t;

  // emitter states
  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_SHOW = 2'b10
  } back_state_t;

  // one good frame, handed from parser to emitter
  typedef struct packed {
    logic [7:0]       message_id;
    logic [7:0]       device_id;
    logic [7:0]       system_id;
    logic [7:0]       seq_num;
    logic [LEN_W-1:0] length;
    logic             range_ok;
  } frame_desc_t;

  // flow status seen by the parser
  typedef struct packed {
    logic q_empty;
    logic q_full;
    logic back_idle;
  } flow_status_t;

endpackage

FILE: src/sfp_ram.sv
module sfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/sfp_front.sv
module sfp_front #(
  parameter int MAX_PAYLOAD = 64,
  localparam int LW = $clog2(MAX_PAYLOAD + 1),
  localparam int AW = $clog2(MAX_PAYLOAD)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [7:0]                       cfg_data,
  input  logic                             rx_valid,
  output logic                             rx_ready,
  input  logic [7:0]                       rx_byte,
  input  sfp_pkg::flow_status_t            flow,
  output logic                             push,
  output sfp_pkg::frame_desc_t             push_desc,
  output logic                             wr_en,
  output logic [AW-1:0]                    wr_addr,
  output logic [7:0]                       wr_data
);

  sfp_pkg::phase_t phase;
  logic [7:0]      head_byte;
  logic [7:0]      range_message_id;
  logic [7:0]      held_device_id;
  logic [7:0]      held_system_id;
  logic [7:0]      held_message_id;
  logic [7:0]      held_sequence;
  logic [LW-1:0]   held_length;
  logic [LW-1:0]   byte_count;
  logic [7:0]      running_sum;
  logic            entry_a_one;
  logic            entry_b_one;

  logic            accept;
  logic [LW-1:0]   count_inc;
  logic            sum_good;

  // payload bytes wait for the store to drain, checksum waits for queue room
  always_comb begin
    unique case (phase)
      sfp_pkg::PH_DATA: rx_ready = flow.back_idle && flow.q_empty;
      sfp_pkg::PH_SUM:  rx_ready = !flow.q_full;
      default:          rx_ready = 1'b1;
    endcase
  end

  assign accept    = rx_valid && rx_ready;
  assign count_inc = byte_count + LW'(1);
  assign sum_good  = rx_byte == running_sum;

  // payload store write
  assign wr_en   = accept && (phase == sfp_pkg::PH_DATA);
  assign wr_addr = byte_count[AW-1:0];
  assign wr_data = rx_byte;

  // descriptor of a good frame
  assign push                 = accept && (phase == sfp_pkg::PH_SUM) && sum_good;
  assign push_desc.message_id = held_message_id;
  assign push_desc.device_id  = held_device_id;
  assign push_desc.system_id  = held_system_id;
  assign push_desc.seq_num    = held_sequence;
  assign push_desc.length     = sfp_pkg::LEN_W'(held_length);
  assign push_desc.range_ok   = (held_message_id == range_message_id) &&
                                entry_a_one && entry_b_one;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte        <= sfp_pkg::HEAD_BYTE_RESET;
      range_message_id <= sfp_pkg::RANGE_MESSAGE_ID_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sfp_pkg::REG_HEAD_BYTE:        head_byte        <= cfg_data;
        sfp_pkg::REG_RANGE_MESSAGE_ID: range_message_id <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame parsing
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= sfp_pkg::PH_HUNT;
      held_device_id  <= '0;
      held_system_id  <= '0;
      held_message_id <= '0;
      held_sequence   <= '0;
      held_length     <= '0;
      byte_count      <= '0;
      running_sum     <= '0;
      entry_a_one     <= 1'b0;
      entry_b_one     <= 1'b0;
    end else if (accept) begin
      unique case (phase)
        sfp_pkg::PH_HUNT: begin
          if (rx_byte == head_byte) begin
            running_sum <= rx_byte;
            byte_count  <= '0;
            phase       <= sfp_pkg::PH_DEV;
          end
        end
        sfp_pkg::PH_DEV: begin
          held_device_id <= rx_byte;
          running_sum    <= running_sum + rx_byte;
          phase          <= sfp_pkg::PH_SYS;
        end
        sfp_pkg::PH_SYS: begin
          held_system_id <= rx_byte;
          running_sum    <= running_sum + rx_byte;
          phase          <= sfp_pkg::PH_MSG;
        end
        sfp_pkg::PH_MSG: begin
          held_message_id <= rx_byte;
          running_sum     <= running_sum + rx_byte;
          phase           <= sfp_pkg::PH_SEQ;
        end
        sfp_pkg::PH_SEQ: begin
          held_sequence <= rx_byte;
          running_sum   <= running_sum + rx_byte;
          phase         <= sfp_pkg::PH_LEN;
        end
        sfp_pkg::PH_LEN: begin
          running_sum <= running_sum + rx_byte;
          byte_count  <= '0;
          // oversize length aborts, zero length skips the payload
          if (rx_byte > 8'(MAX_PAYLOAD)) begin
            phase <= sfp_pkg::PH_HUNT;
          end else begin
            held_length <= rx_byte[LW-1:0];
            phase       <= (rx_byte == 8'd0) ? sfp_pkg::PH_SUM : sfp_pkg::PH_DATA;
          end
        end
        sfp_pkg::PH_DATA: begin
          running_sum <= running_sum + rx_byte;
          // track the two entries checked by the range flag
          if (byte_count == LW'(sfp_pkg::RANGE_INDEX_A)) begin
            entry_a_one <= rx_byte == sfp_pkg::RANGE_FLAG_VALUE;
          end
          if (byte_count == LW'(sfp_pkg::RANGE_INDEX_B)) begin
            entry_b_one <= rx_byte == sfp_pkg::RANGE_FLAG_VALUE;
          end
          if (count_inc >= held_length) begin
            byte_count <= '0;
            phase      <= sfp_pkg::PH_SUM;
          end else begin
            byte_count <= count_inc;
          end
        end
        sfp_pkg::PH_SUM: begin
          byte_count <= '0;
          phase      <= sfp_pkg::PH_HUNT;
        end
        default: begin
          phase <= sfp_pkg::PH_HUNT;
        end
      endcase
    end
  end

endmodule

FILE: src/sfp_queue.sv
module sfp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sfp_pkg::frame_desc_t push_desc,
  input  logic                 pop,
  output sfp_pkg::frame_desc_t pop_desc,
  output logic                 empty,
  output logic                 full
);

  sfp_pkg::frame_desc_t             entry [sfp_pkg::QUEUE_DEPTH];
  logic [sfp_pkg::QUEUE_PTR_W-1:0]  wr_ptr;
  logic [sfp_pkg::QUEUE_PTR_W-1:0]  rd_ptr;
  logic [sfp_pkg::QUEUE_CNT_W-1:0]  count;
  logic                             do_push;
  logic                             do_pop;

  assign empty    = count == '0;
  assign full     = count == sfp_pkg::QUEUE_CNT_W'(sfp_pkg::QUEUE_DEPTH);
  assign pop_desc = entry[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // descriptor storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_desc;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == sfp_pkg::QUEUE_PTR_W'(sfp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == sfp_pkg::QUEUE_PTR_W'(sfp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/sfp_back.sv
module sfp_back #(
  parameter int MAX_PAYLOAD = 64,
  localparam int LW = $clog2(MAX_PAYLOAD + 1),
  localparam int AW = $clog2(MAX_PAYLOAD)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  sfp_pkg::frame_desc_t q_desc,
  output logic                 pop,
  output logic                 back_idle,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  logic [7:0]           rd_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           payload_byte,
  output logic [5:0]           payload_index,
  output logic                 has_payload,
  output logic                 last,
  output logic [7:0]           frame_message_id,
  output logic [7:0]           frame_device_id,
  output logic [7:0]           frame_system_id,
  output logic [7:0]           frame_sequence,
  output logic [6:0]           frame_length,
  output logic                 range_accepted
);

  sfp_pkg::back_state_t state;
  sfp_pkg::frame_desc_t cur;
  logic [LW-1:0]        idx;
  logic [LW-1:0]        idx_inc;
  logic                 out_take;

  assign back_idle = state == sfp_pkg::BK_IDLE;
  assign pop       = back_idle && !q_empty;
  assign out_valid = state == sfp_pkg::BK_SHOW;
  assign out_take  = out_valid && out_ready;
  assign idx_inc   = idx + LW'(1);

  // result fields, payload byte comes straight from the store read register
  assign has_payload      = cur.length != '0;
  assign last             = !has_payload || (idx_inc == LW'(cur.length));
  assign payload_byte     = has_payload ? rd_data : 8'd0;
  assign payload_index    = 6'(idx);
  assign frame_message_id = cur.message_id;
  assign frame_device_id  = cur.device_id;
  assign frame_system_id  = cur.system_id;
  assign frame_sequence   = cur.seq_num;
  assign frame_length     = 7'(cur.length);
  assign range_accepted   = cur.range_ok;

  // store read: first entry on pop, next entry when a result is taken
  always_comb begin
    unique case (state)
      sfp_pkg::BK_IDLE: begin
        rd_en   = pop && (q_desc.length != '0);
        rd_addr = '0;
      end
      sfp_pkg::BK_SHOW: begin
        rd_en   = out_take && !last;
        rd_addr = idx_inc[AW-1:0];
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  // descriptor register
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_desc;
    end
  end

  // emitter sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfp_pkg::BK_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        sfp_pkg::BK_IDLE: begin
          if (pop) begin
            idx   <= '0;
            state <= sfp_pkg::BK_SHOW;
          end
        end
        sfp_pkg::BK_SHOW: begin
          if (out_take) begin
            if (last) begin
              state <= sfp_pkg::BK_IDLE;
            end else begin
              idx <= idx_inc;
            end
          end
        end
        default: begin
          state <= sfp_pkg::BK_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/sensor_frame_parser.sv
// result path: checksum accept queues the descriptor, the idle emitter pops and shows it
// throughput: one rx byte per cycle when rx_ready, one result per cycle when out_ready;
//   payload bytes of a frame are held off while the previous frame's payload run drains from the store
// reset: synchronous on rst; parser hunts for the head byte, queue and emitter empty,
//   head_byte 239, range_message_id 81; the payload store is not cleared
module sensor_frame_parser #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [7:0]                       cfg_data,
  input  logic                             rx_valid,
  output logic                             rx_ready,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       payload_byte,
  output logic [5:0]                       payload_index,
  output logic                             has_payload,
  output logic                             last,
  output logic [7:0]                       frame_message_id,
  output logic [7:0]                       frame_device_id,
  output logic [7:0]                       frame_system_id,
  output logic [7:0]                       frame_sequence,
  output logic [6:0]                       frame_length,
  output logic                             range_accepted
);

  localparam int AW = $clog2(MAX_PAYLOAD);

  sfp_pkg::flow_status_t flow;
  sfp_pkg::frame_desc_t  push_desc;
  sfp_pkg::frame_desc_t  pop_desc;
  logic                  push;
  logic                  pop;
  logic                  q_empty;
  logic                  q_full;
  logic                  back_idle;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [7:0]            wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [7:0]            rd_data;

  assign flow.q_empty   = q_empty;
  assign flow.q_full    = q_full;
  assign flow.back_idle = back_idle;

  // parser: hunts, captures header, writes payload, checks sum
  sfp_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .rx_byte   (rx_byte),
    .flow      (flow),
    .push      (push),
    .push_desc (push_desc),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // payload store
  sfp_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // good-frame descriptors
  sfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .empty     (q_empty),
    .full      (q_full)
  );

  // emitter: plays out the payload run of each good frame
  sfp_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_desc           (pop_desc),
    .pop              (pop),
    .back_idle        (back_idle),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .payload_byte     (payload_byte),
    .payload_index    (payload_index),
    .has_payload      (has_payload),
    .last             (last),
    .frame_message_id (frame_message_id),
    .frame_device_id  (frame_device_id),
    .frame_system_id  (frame_system_id),
    .frame_sequence   (frame_sequence),
    .frame_length     (frame_length),
    .range_accepted   (range_accepted)
  );

endmodule
